// ===== sv/arinc429_word_transmitter_defines.svh =====
// Assertion macros shared by the transmitter's top level.
`ifndef ARINC429_WORD_TRANSMITTER_DEFINES_SVH
`define ARINC429_WORD_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define A429TX_ASSERT_NOW(lbl, pre, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked while reset is held.
`define A429TX_ASSERT_NEXT(lbl, pre, cons, msg) \
    lbl: assert property (@(posedge aclk) (pre) |=> (cons)) else $error(msg);

`endif

// ===== sv/a429tx_pkg.sv =====
// Types, constants and helper functions of the ARINC 429 word transmitter.
package a429tx_pkg;

    // Input transaction: a tick or a send request
    typedef struct packed {
        logic        kind;
        logic [7:0]  label;
        logic [1:0]  sdi;
        logic [16:0] value;
        logic [1:0]  ssm;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic        line_hi;
        logic        line_lo;
        logic        busy_res;
        logic        accepted;
        logic [31:0] built_word;
        logic        word_done;
    } out_t;

    // Front stage: request fields plus the upper half of the BCD conversion
    typedef struct packed {
        logic        kind;
        logic [7:0]  label;
        logic [1:0]  sdi;
        logic [1:0]  ssm;
        logic [11:0] bcd_hi;
        logic [7:0]  val_lo;
    } front_t;

    // Timing registers
    typedef struct packed {
        logic [9:0] high_ticks;
        logic [9:0] null_ticks;
    } cfg_t;

    // Line phase of the transmitter
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DRIVE,
        PH_NULL
    } phase_t;

    localparam int          APB_ADDR_W     = 3;
    localparam logic        KIND_TICK      = 1'b0;
    localparam logic        KIND_SEND      = 1'b1;
    localparam logic        REG_HIGH_TICKS = 1'b0;
    localparam logic        REG_NULL_TICKS = 1'b1;
    localparam logic [9:0]  HIGH_TICKS_RST = 10'd24;
    localparam logic [9:0]  NULL_TICKS_RST = 10'd40;
    localparam logic [5:0]  WORD_BITS      = 6'd32;
    localparam int          BCD_DATA_BITS  = 19;

    // One double-dabble step: add 3 to each digit of 5 or more, then shift in a bit
    function automatic logic [23:0] bcd_step(input logic [23:0] b, input logic din);
        logic [23:0] r;
        r = b;
        for (int d = 0; d < 6; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
                r[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
        end
        return {r[22:0], din};
    endfunction

    // Label goes on the wire MSB first, so it is stored reversed
    function automatic logic [7:0] rev8(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = x[i];
        end
        return r;
    endfunction

endpackage

// ===== sv/a429tx_regs.sv =====
// APB register file holding the bit and null phase lengths.
module a429tx_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [a429tx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output a429tx_pkg::cfg_t                  cfg
);
    import a429tx_pkg::*;

    logic [9:0] high_ticks_reg;
    logic [9:0] null_ticks_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_ticks_reg <= HIGH_TICKS_RST;
            null_ticks_reg <= NULL_TICKS_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_HIGH_TICKS: high_ticks_reg <= pwdata[9:0];
                REG_NULL_TICKS: null_ticks_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[2])
            REG_HIGH_TICKS: prdata = {22'd0, high_ticks_reg};
            REG_NULL_TICKS: prdata = {22'd0, null_ticks_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.high_ticks = high_ticks_reg;
    assign cfg.null_ticks = null_ticks_reg;

endmodule

// ===== sv/a429tx_front.sv =====
// Input register with the first half of the binary to BCD conversion.
module a429tx_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                s_valid,
    input  a429tx_pkg::in_t     s_data,
    output logic                f_valid,
    output a429tx_pkg::front_t  f_data
);
    import a429tx_pkg::*;

    logic        f_valid_reg;
    front_t      f_data_reg;
    front_t      f_data_next;
    logic [23:0] bcd;

    // Top three bits need no correction; the next six take one step each
    always_comb begin
        bcd = {21'd0, s_data.value[16:14]};
        for (int i = 13; i >= 8; i--) begin
            bcd = bcd_step(bcd, s_data.value[i]);
        end
        f_data_next.kind   = s_data.kind;
        f_data_next.label  = s_data.label;
        f_data_next.sdi    = s_data.sdi;
        f_data_next.ssm    = s_data.ssm;
        f_data_next.bcd_hi = bcd[11:0];
        f_data_next.val_lo = s_data.value[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            f_data_reg <= f_data_next;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_data  = f_data_reg;

endmodule

// ===== sv/a429tx_seq.sv =====
// Word assembly, line sequencer and result register.
module a429tx_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                f_valid,
    input  a429tx_pkg::front_t  f_data,
    input  a429tx_pkg::cfg_t    cfg,
    output logic                m_valid,
    output a429tx_pkg::out_t    m_data
);
    import a429tx_pkg::*;

    phase_t      state_reg, state_next;
    logic [31:0] word_reg, word_next;
    logic [5:0]  bits_reg, bits_next;
    logic [9:0]  count_reg, count_next;
    logic        m_valid_reg;
    out_t        out_reg, out_next;

    logic [23:0] bcd;
    logic [30:0] word_raw;
    logic [31:0] new_word;
    logic [9:0]  hlim, nlim, count_inc;
    logic [5:0]  bits_dec;
    logic        accepted, done;
    logic [5:0]  idx_full;
    logic        bit_out, drive;
    logic        step;

    assign step = en && f_valid;

    // Second half of the BCD conversion and word assembly with odd parity
    always_comb begin
        bcd = {12'd0, f_data.bcd_hi};
        for (int i = 7; i >= 0; i--) begin
            bcd = bcd_step(bcd, f_data.val_lo[i]);
        end
        word_raw = {f_data.ssm, bcd[BCD_DATA_BITS-1:0], f_data.sdi, rev8(f_data.label)};
        new_word = {~(^word_raw), word_raw};
    end

    // A zero length acts as one tick
    assign hlim      = (cfg.high_ticks == 10'd0) ? 10'd1 : cfg.high_ticks;
    assign nlim      = (cfg.null_ticks == 10'd0) ? 10'd1 : cfg.null_ticks;
    assign count_inc = count_reg + 10'd1;
    assign bits_dec  = (bits_reg != 6'd0) ? bits_reg - 6'd1 : bits_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        word_next  = word_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        accepted   = 1'b0;
        done       = 1'b0;
        if (f_data.kind == KIND_SEND) begin
            if (state_reg == PH_IDLE) begin
                word_next  = new_word;
                bits_next  = WORD_BITS;
                count_next = 10'd0;
                state_next = PH_DRIVE;
                accepted   = 1'b1;
            end
        end else begin
            case (state_reg)
                PH_DRIVE: begin
                    count_next = count_inc;
                    if (count_inc >= hlim) begin
                        count_next = 10'd0;
                        state_next = PH_NULL;
                    end
                end
                PH_NULL: begin
                    count_next = count_inc;
                    if (count_inc >= nlim) begin
                        count_next = 10'd0;
                        bits_next  = bits_dec;
                        if (bits_dec == 6'd0) begin
                            state_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            state_next = PH_DRIVE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Outputs: current bit, sent LSB first
    always_comb begin
        idx_full = WORD_BITS - bits_next;
        bit_out  = word_next[idx_full[4:0]];
        drive    = (state_next == PH_DRIVE) && (bits_next != 6'd0) && (bits_next <= WORD_BITS);
        out_next.line_hi    = drive && bit_out;
        out_next.line_lo    = drive && !bit_out;
        out_next.busy_res   = (state_next != PH_IDLE);
        out_next.accepted   = accepted;
        out_next.built_word = word_next;
        out_next.word_done  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PH_IDLE;
            word_reg    <= 32'd0;
            bits_reg    <= 6'd0;
            count_reg   <= 10'd0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= f_valid;
            if (f_valid) begin
                state_reg <= state_next;
                word_reg  <= word_next;
                bits_reg  <= bits_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/arinc429_word_transmitter.sv =====
// ARINC 429 word transmitter, top level.
//
// Input channel (s_valid/s_ready/s_data): each transaction is either a
// one-microsecond tick (kind 0) or a request to send a word (kind 1). A
// request is taken only while no word is in flight; otherwise it is dropped
// with accepted = 0. Every input transaction yields exactly one result
// transaction on m_valid/m_ready/m_data carrying the line drive, busy flag,
// accepted flag, assembled word and word-done flag.
// An input register holds the transaction and the upper half of the BCD
// conversion, and a result register holds the line state. Throughput is
// one transaction per cycle while the receiver does not stall, with the
// sequencer update combinational between those two registers.
// When the receiver stalls, both stages hold and s_ready drops; the stalled
// result is kept until taken, and the next input is accepted in that cycle.
// Reset clears valid flags and sequencer, not result data, and loads the
// bit length to 24 ticks and null length to 40 ticks. The APB port writes
// both; the user must use it only while idle, as the block does not check.
module arinc429_word_transmitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  a429tx_pkg::in_t                   s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output a429tx_pkg::out_t                  m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [a429tx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import a429tx_pkg::*;

`include "arinc429_word_transmitter_defines.svh"

    cfg_t   cfg;
    front_t f_data;
    logic   f_valid;
    logic   en;

    // Whole pipeline advances unless a result is waiting and stalled
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    a429tx_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    a429tx_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_valid),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_data  (f_data)
    );

    a429tx_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .f_valid (f_valid),
        .f_data  (f_data),
        .cfg     (cfg),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // Checks
    `A429TX_ASSERT_NOW(a_accept_drives, m_valid && m_data.accepted, m_data.busy_res && (m_data.line_hi != m_data.line_lo) && !m_data.word_done, "accepted request must drive its first bit")
    `A429TX_ASSERT_NOW(a_done_idle, m_valid && m_data.word_done, !m_data.busy_res && !m_data.line_hi && !m_data.line_lo, "word_done must leave the lines idle")
    `A429TX_ASSERT_NOW(a_lines_exclusive, m_valid && !m_data.busy_res, !m_data.line_hi && !m_data.line_lo, "lines driven while not busy")
    `A429TX_ASSERT_NEXT(a_reset_clear, !aresetn, !m_valid && s_ready, "reset must empty the pipeline")

endmodule

// ===== tb/a429tx_word_checker.sv =====
// Line-state predictor and result checker for the ARINC 429 word transmitter.
`timescale 1ns / 100ps

module a429tx_word_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  a429tx_pkg::in_t                   s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  a429tx_pkg::out_t                  m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [a429tx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    input  logic [31:0]                       prdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending,
    output logic                              word_in_flight
);
    import a429tx_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Timing registers as last written
    logic [9:0]  drive_ticks;
    logic [9:0]  null_ticks_cfg;

    // Transmit sequencer
    logic [31:0] tx_word;
    logic [5:0]  bits_to_send;
    logic        in_null;
    logic [9:0]  phase_ticks;
    logic        tx_busy;

    out_t        expected_lines[$];
    out_t        oldest;

    // BCD of the value, label reversed, odd parity in bit 31
    function automatic logic [31:0] assemble_word(input in_t req);
        logic [31:0] w;
        logic [31:0] bcd;
        int unsigned n;
        n   = req.value;
        bcd = '0;
        for (int d = 0; d < 6; d++) begin
            bcd[4*d +: 4] = 4'(n % 10);
            n = n / 10;
        end
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[7-i] = req.label[i];
        end
        w[9:8]   = req.sdi;
        w[28:10] = bcd[18:0];
        w[30:29] = req.ssm;
        w[31]    = ~^w[30:0];
        return w;
    endfunction

    // Advance the sequencer by one input transaction, return the line state after it
    function automatic out_t line_step(input in_t item);
        out_t       r;
        logic [9:0] hl;
        logic [9:0] nl;
        logic [4:0] idx;
        logic       took;
        logic       done;
        took = 1'b0;
        done = 1'b0;
        if (item.kind == KIND_SEND) begin
            // request while busy is dropped and does not count as time
            if (!tx_busy) begin
                tx_word      = assemble_word(item);
                bits_to_send = WORD_BITS;
                in_null      = 1'b0;
                phase_ticks  = '0;
                tx_busy      = 1'b1;
                took         = 1'b1;
            end
        end else if (tx_busy) begin
            // a zero length behaves as one tick
            hl = (drive_ticks == 10'd0) ? 10'd1 : drive_ticks;
            nl = (null_ticks_cfg == 10'd0) ? 10'd1 : null_ticks_cfg;
            phase_ticks = phase_ticks + 10'd1;
            if (!in_null) begin
                if (phase_ticks >= hl) begin
                    in_null     = 1'b1;
                    phase_ticks = '0;
                end
            end else if (phase_ticks >= nl) begin
                in_null     = 1'b0;
                phase_ticks = '0;
                if (bits_to_send != 6'd0) begin
                    bits_to_send = bits_to_send - 6'd1;
                end
                if (bits_to_send == 6'd0) begin
                    tx_busy = 1'b0;
                    done    = 1'b1;
                end
            end
        end

        r = '0;
        if (tx_busy && !in_null && bits_to_send != 6'd0 && bits_to_send <= WORD_BITS) begin
            idx       = 5'(WORD_BITS - bits_to_send);
            r.line_hi = tx_word[idx];
            r.line_lo = ~tx_word[idx];
        end
        r.busy_res   = tx_busy;
        r.accepted   = took;
        r.built_word = tx_word;
        r.word_done  = done;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%t checker: %s mismatch, expected %h, got %h",
                         $time, name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            drive_ticks    = HIGH_TICKS_RST;
            null_ticks_cfg = NULL_TICKS_RST;
            tx_word        = '0;
            bits_to_send   = '0;
            in_null        = 1'b0;
            phase_ticks    = '0;
            tx_busy        = 1'b0;
            expected_lines.delete();
        end else begin
            // register writes and read-back
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_HIGH_TICKS) begin
                    drive_ticks = pwdata[9:0];
                end else begin
                    null_ticks_cfg = pwdata[9:0];
                end
            end
            if (psel && penable && !pwrite && pready) begin
                check_field("prdata",
                            {22'd0, (paddr[2] == REG_HIGH_TICKS) ? drive_ticks : null_ticks_cfg},
                            {22'd0, prdata[9:0]});
            end

            // result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%t checker: result %h with no expected transaction waiting",
                                 $time, m_data);
                    end
                end else begin
                    oldest = expected_lines.pop_front();
                    check_field("line_hi", 32'(oldest.line_hi), 32'(m_data.line_hi));
                    check_field("line_lo", 32'(oldest.line_lo), 32'(m_data.line_lo));
                    check_field("busy_res", 32'(oldest.busy_res), 32'(m_data.busy_res));
                    check_field("accepted", 32'(oldest.accepted), 32'(m_data.accepted));
                    check_field("built_word", oldest.built_word, m_data.built_word);
                    check_field("word_done", 32'(oldest.word_done), 32'(m_data.word_done));
                end
            end

            // input transaction: predict its line state
            if (s_valid && s_ready) begin
                expected_lines.push_back(line_step(s_data));
            end
        end
        pending        = expected_lines.size();
        word_in_flight = tx_busy;
    end

endmodule

// ===== tb/arinc429_word_transmitter_tb.sv =====
// Stimulus and verdict for the ARINC 429 word transmitter testbench.
`timescale 1ns / 100ps

module arinc429_word_transmitter_tb;
    import a429tx_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int RANDOM_PHASES   = 5;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    logic                  word_in_flight;
    bit                    quiet;
    int                    cycles;

    arinc429_word_transmitter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    a429tx_word_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .word_in_flight (word_in_flight)
    );

    // 100 MHz clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("arinc429_word_transmitter_tb: FAIL");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
        end
    end

    // random fields, every bit reachable; value mostly within the BCD range
    function automatic in_t rand_fields();
        in_t r;
        r       = '0;
        r.kind  = KIND_TICK;
        r.label = 8'($urandom);
        r.sdi   = 2'($urandom);
        r.value = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 99999));
        r.ssm   = 2'($urandom);
        return r;
    endfunction

    function automatic in_t make_send(input logic [7:0] label, input logic [1:0] sdi,
                                      input logic [16:0] value, input logic [1:0] ssm);
        in_t r;
        r.kind  = KIND_SEND;
        r.label = label;
        r.sdi   = sdi;
        r.value = value;
        r.ssm   = ssm;
        return r;
    endfunction

    // Called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_item(input in_t item);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic go_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // Tick until the word on the line is finished, then drain
    task automatic finish_word();
        while (word_in_flight) drive_item(rand_fields());
        go_idle();
    endtask

    task automatic send_word(input in_t req);
        drive_item(req);
        finish_word();
    endtask

    // One APB transfer: setup cycle, then access cycle
    task automatic apb_access(input logic reg_sel, input logic wr, input logic [9:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({reg_sel, 2'b00});
        pwdata  <= {22'($urandom), val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_timing(input logic [9:0] hi_len, input logic [9:0] null_len);
        apb_access(REG_HIGH_TICKS, 1'b1, hi_len);
        apb_access(REG_NULL_TICKS, 1'b1, null_len);
        apb_access(REG_HIGH_TICKS, 1'b0, 10'd0);
        apb_access(REG_NULL_TICKS, 1'b0, 10'd0);
    endtask

    // Mostly ticks while a word is out, a send soon after it ends
    task automatic random_traffic(input int count);
        in_t item;
        for (int i = 0; i < count; i++) begin
            item = rand_fields();
            if (word_in_flight ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 1) == 0)) begin
                item.kind = KIND_SEND;
            end
            drive_item(item);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        quiet   = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset lengths read back, idle tick leaves the lines low
        apb_access(REG_HIGH_TICKS, 1'b0, 10'd0);
        apb_access(REG_NULL_TICKS, 1'b0, 10'd0);
        drive_item(rand_fields());
        go_idle();

        // full word with a request dropped while busy
        set_timing(10'd1, 10'd1);
        drive_item(make_send(8'hFF, 2'd3, 17'd99999, 2'd3));
        drive_item(make_send(8'h00, 2'd0, 17'd0, 2'd0));
        finish_word();

        // field extremes, BCD top digit 7 and 8, value past 99999
        send_word(make_send(8'h00, 2'd0, 17'd0, 2'd0));
        send_word(make_send(8'h80, 2'd1, 17'd1, 2'd2));
        send_word(make_send(8'h5A, 2'd2, 17'h1FFFF, 2'd1));
        send_word(make_send(8'h01, 2'd3, 17'd79999, 2'd0));
        send_word(make_send(8'hC3, 2'd1, 17'd80000, 2'd3));
        send_word(make_send(8'h3C, 2'd0, 17'd12345, 2'd2));

        // request in the middle of a word
        drive_item(make_send(8'hA5, 2'd2, 17'd4321, 2'd1));
        repeat (5) drive_item(rand_fields());
        drive_item(make_send(8'h0F, 2'd1, 17'd55555, 2'd3));
        finish_word();

        // zero lengths act as one tick
        set_timing(10'd0, 10'd0);
        send_word(make_send(8'h96, 2'd2, 17'd99998, 2'd0));

        // random traffic over several timings, the last one without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    set_timing(10'd1, 10'd1);
                end
                1: begin
                    set_timing(10'd2, 10'd1);
                end
                2: begin
                    set_timing(10'd1, 10'd3);
                end
                3: begin
                    set_timing(10'($urandom_range(1, 5)), 10'($urandom_range(1, 5)));
                end
                default: begin
                    set_timing(10'd3, 10'd2);
                    quiet = 1'b1;
                end
            endcase
            random_traffic(ITEMS_PER_PHASE);
            if (p < RANDOM_PHASES - 1) begin
                finish_word();
            end
        end

        go_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("arinc429_word_transmitter_tb: PASS");
        end else begin
            $display("arinc429_word_transmitter_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/a429tx_pkg.sv
sv/a429tx_regs.sv
sv/a429tx_front.sv
sv/a429tx_seq.sv
sv/arinc429_word_transmitter.sv
tb/a429tx_word_checker.sv
tb/arinc429_word_transmitter_tb.sv
